// ----- design/bwr_pkg.sv -----
// Shared types, constants and the control program of the windowed busy ratio monitor.
package bwr_pkg;

  localparam int RING_DEPTH_DEF      = 64;
  localparam int RATIO_FRAC_BITS_DEF = 16;

  localparam int TIME_W   = 64;
  localparam int WINDOW_W = 40;
  localparam int STATUS_W = 2;
  localparam int PC_W     = 4;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 40'd1000000000;

  localparam logic [STATUS_W-1:0] ST_MEASURED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FEW       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WALL_ZERO = 2'd2;

  localparam logic [PC_W-1:0] PC_IDLE      = 4'd0;
  localparam logic [PC_W-1:0] PC_FILL      = 4'd1;
  localparam logic [PC_W-1:0] PC_READ      = 4'd2;
  localparam logic [PC_W-1:0] PC_WALK      = 4'd3;
  localparam logic [PC_W-1:0] PC_ZERO      = 4'd4;
  localparam logic [PC_W-1:0] PC_CLAMP     = 4'd5;
  localparam logic [PC_W-1:0] PC_DIV       = 4'd6;
  localparam logic [PC_W-1:0] PC_EMIT_QUOT = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT_ONE  = 4'd8;
  localparam logic [PC_W-1:0] PC_EMIT_FEW  = 4'd9;
  localparam logic [PC_W-1:0] PC_EMIT_ZERO = 4'd10;

  typedef enum logic [3:0] {
    U_NOP,
    U_ACCEPT,
    U_LOAD_ADV,
    U_DIV_INIT,
    U_DIV_STEP,
    U_EMIT_QUOT,
    U_EMIT_ONE,
    U_EMIT_FEW,
    U_EMIT_ZERO
  } uop_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_FEW,
    C_WALK_MORE,
    C_WALL_ZERO,
    C_BUSY_GE,
    C_DIV_MORE
  } cond_t;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            take;
    logic            wait_out;
  } ctrl_t;

  typedef struct packed {
    logic few;
    logic walk_more;
    logic wall_zero;
    logic busy_ge;
    logic div_more;
  } dp_flags_t;

  // Control store: one word per step, jumps taken when the condition holds.
  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{op: U_NOP, cond: C_NEVER, target: PC_IDLE, take: 1'b0, wait_out: 1'b0};
    unique case (pc)
      PC_IDLE: begin
        w.op     = U_ACCEPT;
        w.cond   = C_NO_IN;
        w.target = PC_IDLE;
        w.take   = 1'b1;
      end
      PC_FILL: begin
        w.cond   = C_FEW;
        w.target = PC_EMIT_FEW;
      end
      PC_READ: begin
        w.cond = C_NEVER;
      end
      PC_WALK: begin
        w.op     = U_LOAD_ADV;
        w.cond   = C_WALK_MORE;
        w.target = PC_READ;
      end
      PC_ZERO: begin
        w.cond   = C_WALL_ZERO;
        w.target = PC_EMIT_ZERO;
      end
      PC_CLAMP: begin
        w.op     = U_DIV_INIT;
        w.cond   = C_BUSY_GE;
        w.target = PC_EMIT_ONE;
      end
      PC_DIV: begin
        w.op     = U_DIV_STEP;
        w.cond   = C_DIV_MORE;
        w.target = PC_DIV;
      end
      PC_EMIT_QUOT: begin
        w.op       = U_EMIT_QUOT;
        w.cond     = C_ALWAYS;
        w.wait_out = 1'b1;
      end
      PC_EMIT_ONE: begin
        w.op       = U_EMIT_ONE;
        w.cond     = C_ALWAYS;
        w.wait_out = 1'b1;
      end
      PC_EMIT_FEW: begin
        w.op       = U_EMIT_FEW;
        w.cond     = C_ALWAYS;
        w.wait_out = 1'b1;
      end
      PC_EMIT_ZERO: begin
        w.op       = U_EMIT_ZERO;
        w.cond     = C_ALWAYS;
        w.wait_out = 1'b1;
      end
      default: begin
        w.cond = C_ALWAYS;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- design/bwr_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module bwr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bwr_seq.sv -----
// Microcode sequencer: step counter, control store and conditional jumps.
module bwr_seq
  import bwr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  dp_flags_t flags,
  input  logic      in_valid,
  input  logic      out_busy,
  output ctrl_t     ctrl,
  output logic      go
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            stall;
  logic            taken;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    ctrl  = ucode(pc);
    stall = ctrl.wait_out && out_busy;
    unique case (ctrl.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_NO_IN:     taken = !in_valid;
      C_FEW:       taken = flags.few;
      C_WALK_MORE: taken = flags.walk_more;
      C_WALL_ZERO: taken = flags.wall_zero;
      C_BUSY_GE:   taken = flags.busy_ge;
      C_DIV_MORE:  taken = flags.div_more;
      default:     taken = 1'b0;
    endcase
    go = !stall && !(ctrl.op == U_ACCEPT && !in_valid);
    priority if (stall) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = ctrl.target;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  a_pc_in_program: assert property (@(posedge clk) disable iff (rst)
    pc <= PC_EMIT_ZERO)
    else $error("step counter left the program");

endmodule

// ----- design/bwr_datapath.sv -----
// Datapath: sample rings, reference walk, delta registers and the serial divider.
module bwr_datapath
  import bwr_pkg::*;
#(
  parameter int RING_DEPTH      = RING_DEPTH_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctrl_t                      ctrl,
  input  logic                       go,
  input  logic [TIME_W-1:0]          in_wall,
  input  logic [TIME_W-1:0]          in_busy,
  input  logic [WINDOW_W-1:0]        window,
  output dp_flags_t                  flags,
  output logic                       emit_valid,
  output logic [RATIO_FRAC_BITS:0]   emit_ratio,
  output logic [STATUS_W-1:0]        emit_status
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int FCW = $clog2(RING_DEPTH + 1);
  localparam int CW  = $clog2(RATIO_FRAC_BITS);
  localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
  localparam logic [RATIO_FRAC_BITS:0] RATIO_ONE = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

  logic [AW-1:0]              write_slot;
  logic [FCW-1:0]             fill_count;
  logic [AW-1:0]              rd_ptr;
  logic [FCW-1:0]             k;
  logic [TIME_W-1:0]          wall_new;
  logic [TIME_W-1:0]          busy_new;
  logic [TIME_W-1:0]          wall_span;
  logic [TIME_W-1:0]          busy_delta;
  logic [TIME_W-1:0]          rem;
  logic [RATIO_FRAC_BITS-1:0] quot;
  logic [CW-1:0]              cnt;

  logic [TIME_W-1:0] wall_rd;
  logic [TIME_W-1:0] busy_rd;
  logic [TIME_W-1:0] wall_diff;
  logic [TIME_W-1:0] busy_diff;
  logic [TIME_W:0]   rem_shift;
  logic [TIME_W:0]   den;
  logic [TIME_W:0]   rem_sub;
  logic              bit_set;
  logic              ring_we;
  logic [AW-1:0]     newest_slot;

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    return (s == '0) ? LAST_SLOT : s - AW'(1);
  endfunction

  assign ring_we     = go && (ctrl.op == U_ACCEPT);
  assign newest_slot = slot_dec(write_slot);

  bwr_ram #(.WIDTH(TIME_W), .DEPTH(RING_DEPTH)) u_wall_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (in_wall),
    .raddr (rd_ptr),
    .rdata (wall_rd)
  );

  bwr_ram #(.WIDTH(TIME_W), .DEPTH(RING_DEPTH)) u_busy_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (write_slot),
    .wdata (in_busy),
    .raddr (rd_ptr),
    .rdata (busy_rd)
  );

  always_comb begin
    wall_diff = wall_new - wall_rd;
    busy_diff = busy_new - busy_rd;
    rem_shift = {rem, 1'b0};
    den       = {1'b0, wall_span};
    rem_sub   = rem_shift - den;
    bit_set   = rem_shift >= den;

    flags.few       = fill_count < FCW'(2);
    flags.walk_more = !((k >= FCW'(2)) &&
                        (wall_diff >= {{(TIME_W - WINDOW_W){1'b0}}, window})) &&
                      ((k + FCW'(1)) != fill_count);
    flags.wall_zero = wall_span == '0;
    flags.busy_ge   = busy_delta >= wall_span;
    flags.div_more  = cnt != CW'(RATIO_FRAC_BITS - 1);

    emit_valid  = 1'b0;
    emit_ratio  = RATIO_ONE;
    emit_status = ST_MEASURED;
    if (go) begin
      unique case (ctrl.op)
        U_EMIT_QUOT: begin
          emit_valid = 1'b1;
          emit_ratio = {1'b0, quot};
        end
        U_EMIT_ONE: begin
          emit_valid = 1'b1;
        end
        U_EMIT_FEW: begin
          emit_valid  = 1'b1;
          emit_status = ST_FEW;
        end
        U_EMIT_ZERO: begin
          emit_valid  = 1'b1;
          emit_status = ST_WALL_ZERO;
        end
        default: begin
          emit_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (ring_we) begin
      write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + AW'(1);
      if (fill_count != FCW'(RING_DEPTH)) begin
        fill_count <= fill_count + FCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      unique case (ctrl.op)
        U_ACCEPT: begin
          wall_new <= in_wall;
          busy_new <= in_busy;
          rd_ptr   <= slot_dec(write_slot);
          k        <= FCW'(1);
        end
        U_LOAD_ADV: begin
          wall_span  <= wall_diff;
          busy_delta <= busy_diff;
          k          <= k + FCW'(1);
          rd_ptr     <= slot_dec(rd_ptr);
        end
        U_DIV_INIT: begin
          rem  <= busy_delta;
          quot <= '0;
          cnt  <= '0;
        end
        U_DIV_STEP: begin
          rem  <= bit_set ? rem_sub[TIME_W-1:0] : rem_shift[TIME_W-1:0];
          quot <= {quot[RATIO_FRAC_BITS-2:0], bit_set};
          cnt  <= cnt + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FCW'(RING_DEPTH))
    else $error("fill count beyond ring depth");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (go && ctrl.op == U_LOAD_ADV) |-> (k >= FCW'(1)) && (k < fill_count))
    else $error("walk passed the oldest held sample");

  a_walk_skips_newest: assert property (@(posedge clk) disable iff (rst)
    (go && ctrl.op == U_LOAD_ADV) |-> rd_ptr != newest_slot)
    else $error("walk read the newest slot");

endmodule

// ----- design/windowed_busy_ratio_monitor_top.sv -----
// Top level of the windowed busy ratio monitor: ports, window register, result register.
//
// Each input beat on s_axis carries one sample: tdata[63:0] is the wall-clock
// timestamp and tdata[127:64] the cumulative busy time, both in nanoseconds.
// Each sample yields exactly one result beat on m_axis: tdata holds the busy
// over wall ratio in unsigned fixed point with RATIO_FRAC_BITS fraction bits,
// and tuser holds the status (measured, fewer than two samples, zero wall delta).
// The window in nanoseconds is written through cfg_valid/cfg_data; it should
// only be written while no sample is in flight.
// Samples are handled one at a time by a microcoded sequencer. Walking back through
// the ring passes a read state and a walk state per visited sample, since the read
// of the sample RAMs is registered, and the divider yields one quotient bit a cycle.
// A walk visits 1 to RING_DEPTH-1 samples. Shortcut results skip the divider, and
// with fewer than two samples the walk as well.
// The next sample is taken the cycle after the result is loaded. If the
// receiver stalls, one result waits in the output register while the next
// sample is still taken and processed; that one then waits for the register.
// Reset empties the ring, restores the window to one second and drops any
// pending result.
module windowed_busy_ratio_monitor_top
  import bwr_pkg::*;
#(
  parameter int RING_DEPTH      = RING_DEPTH_DEF,
  parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [2*TIME_W-1:0] s_axis_tdata,  // wall_time, busy_time
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [((RATIO_FRAC_BITS + 8) / 8) * 8 - 1:0] m_axis_tdata,  // ratio, zero fill
  output logic [STATUS_W-1:0] m_axis_tuser,  // status
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WINDOW_W-1:0] cfg_data
);

  localparam int OUT_W = ((RATIO_FRAC_BITS + 8) / 8) * 8;

  logic [WINDOW_W-1:0]      window;
  logic                     out_valid;
  logic [RATIO_FRAC_BITS:0] out_ratio;
  logic [STATUS_W-1:0]      out_status;
  logic                     out_busy;

  ctrl_t                    ctrl;
  logic                     go;
  dp_flags_t                flags;
  logic                     emit_valid;
  logic [RATIO_FRAC_BITS:0] emit_ratio;
  logic [STATUS_W-1:0]      emit_status;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = ctrl.take;
  assign out_busy      = out_valid && !m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = OUT_W'(out_ratio);
  assign m_axis_tuser  = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      window <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      out_ratio  <= emit_ratio;
      out_status <= emit_status;
    end
  end

  bwr_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .flags    (flags),
    .in_valid (s_axis_tvalid),
    .out_busy (out_busy),
    .ctrl     (ctrl),
    .go       (go)
  );

  bwr_datapath #(
    .RING_DEPTH      (RING_DEPTH),
    .RATIO_FRAC_BITS (RATIO_FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .go          (go),
    .in_wall     (s_axis_tdata[TIME_W-1:0]),
    .in_busy     (s_axis_tdata[2*TIME_W-1:TIME_W]),
    .window      (window),
    .flags       (flags),
    .emit_valid  (emit_valid),
    .emit_ratio  (emit_ratio),
    .emit_status (emit_status)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    emit_valid |-> !out_busy)
    else $error("result register overwritten while its beat was pending");

endmodule

// ----- test/tb_windowed_busy_ratio_monitor_top.sv -----
// Self-checking testbench for the windowed busy ratio monitor top level.
module tb_windowed_busy_ratio_monitor_top;
  import bwr_pkg::*;

  localparam int RATIO_W     = RATIO_FRAC_BITS_DEF + 1;
  localparam int SLOT_W      = $clog2(RING_DEPTH_DEF);
  localparam int OUT_W       = ((RATIO_FRAC_BITS_DEF + 8) / 8) * 8;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN       = 2 * RING_DEPTH_DEF + RATIO_FRAC_BITS_DEF + 8;
  localparam int N_PHASES    = 7;
  localparam int PHASE_ITEMS = 205;
  localparam int N_ROWS      = 14;
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC_BITS_DEF;

  typedef struct packed {
    logic [RATIO_W-1:0]  ratio;
    logic [STATUS_W-1:0] status;
  } ratio_res_t;

  typedef struct {
    logic [TIME_W-1:0] wall;
    logic [TIME_W-1:0] busy;
    bit                typed;
    ratio_res_t        res;
  } sample_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [2*TIME_W-1:0] s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WINDOW_W-1:0] cfg_data = '0;

  logic [TIME_W-1:0]   wall_hist [RING_DEPTH_DEF];
  logic [TIME_W-1:0]   busy_hist [RING_DEPTH_DEF];
  logic [SLOT_W-1:0]   hist_slot = '0;
  int                  hist_fill = 0;
  logic [WINDOW_W-1:0] window_reg = WINDOW_RESET;

  ratio_res_t  pending_ratios[$];
  sample_row_t sample_rows[N_ROWS];
  int          mismatches = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;

  windowed_busy_ratio_monitor_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic ratio_res_t predict_busy_ratio(input logic [TIME_W-1:0] wall,
                                                    input logic [TIME_W-1:0] busy);
    logic [SLOT_W-1:0] newest;
    logic [SLOT_W-1:0] ref_slot;
    logic [SLOT_W-1:0] idx;
    logic [TIME_W-1:0] wall_span;
    logic [TIME_W-1:0] busy_delta;
    logic [TIME_W-1:0] rem;
    logic [RATIO_W-1:0] quot;
    logic carry;
    ratio_res_t res;
    newest = hist_slot;
    wall_hist[newest] = wall;
    busy_hist[newest] = busy;
    hist_slot = newest + SLOT_W'(1);
    if (hist_fill < RING_DEPTH_DEF) hist_fill++;
    res.ratio  = RATIO_ONE;
    res.status = ST_FEW;
    if (hist_fill < 2) return res;
    ref_slot = newest - SLOT_W'(1);
    for (int k = 2; k < hist_fill; k++) begin
      idx = newest - SLOT_W'(k);
      ref_slot = idx;
      if (wall - wall_hist[idx] >= TIME_W'(window_reg)) break;
    end
    wall_span = wall - wall_hist[ref_slot];
    if (wall_span == '0) begin
      res.status = ST_WALL_ZERO;
      return res;
    end
    busy_delta = busy - busy_hist[ref_slot];
    res.status = ST_MEASURED;
    if (busy_delta >= wall_span) return res;
    rem  = busy_delta;
    quot = '0;
    for (int b = 0; b < RATIO_FRAC_BITS_DEF; b++) begin
      carry = rem[TIME_W-1];
      rem   = rem << 1;
      quot  = quot << 1;
      if (carry || rem >= wall_span) begin
        rem  = rem - wall_span;
        quot = quot | RATIO_W'(1);
      end
    end
    res.ratio = quot;
    return res;
  endfunction

  task automatic send_sample(input logic [TIME_W-1:0] wall, input logic [TIME_W-1:0] busy,
                             input bit typed, input ratio_res_t typed_res);
    ratio_res_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {busy, wall};
    do @(posedge clk); while (!s_axis_tready);
    res = predict_busy_ratio(wall, busy);
    pending_ratios.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic write_window(input logic [WINDOW_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_ratios.size() != 0) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    window_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall bursts, and one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    ratio_res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_ratios.size() == 0) begin
        $error("result beat with no expected result: ratio %0d, status %0d",
               m_axis_tdata[RATIO_W-1:0], m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_ratios.pop_front();
        if (m_axis_tdata[RATIO_W-1:0] !== want.ratio) begin
          $error("ratio mismatch: expected %0d, actual %0d", want.ratio,
                 m_axis_tdata[RATIO_W-1:0]);
          mismatches++;
        end
        if (m_axis_tuser !== want.status) begin
          $error("status mismatch: expected %0d, actual %0d", want.status, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("windowed_busy_ratio_monitor_top test failed");
    $finish;
  end

  initial begin
    logic [TIME_W-1:0]   cur_wall;
    logic [TIME_W-1:0]   cur_busy;
    logic [TIME_W-1:0]   wall;
    logic [TIME_W-1:0]   busy;
    logic [TIME_W-1:0]   dw;
    logic [TIME_W-1:0]   rnd;
    logic [WINDOW_W-1:0] win;
    int                  sel;
    ratio_res_t          none;
    none = '0;
    sample_rows = '{
      '{64'd0, 64'd0, 1'b1, '{RATIO_ONE, ST_FEW}},
      '{64'd0, 64'd5, 1'b1, '{RATIO_ONE, ST_WALL_ZERO}},
      '{64'd1000, 64'd1000, 1'b1, '{RATIO_ONE, ST_MEASURED}},
      '{64'd2000, 64'd1500, 1'b0, '{'0, ST_MEASURED}},
      '{64'd3000, 64'd1500, 1'b0, '{'0, ST_MEASURED}},
      '{64'd1000003000, 64'd1500, 1'b0, '{'0, ST_MEASURED}},
      '{64'd1000003000, 64'd2000, 1'b0, '{'0, ST_MEASURED}},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '{'0, ST_MEASURED}},
      '{64'd0, 64'd0, 1'b0, '{'0, ST_MEASURED}},
      '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, '{'0, ST_MEASURED}},
      '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, '{'0, ST_MEASURED}},
      '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '{'0, ST_MEASURED}},
      '{64'h5555_5555_932D_FD55, 64'hAAAA_AAAA_AAAA_AAAB, 1'b0, '{'0, ST_MEASURED}},
      '{64'h5555_5555_932D_FD56, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '{'0, ST_MEASURED}}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (sample_rows[r])
      send_sample(sample_rows[r].wall, sample_rows[r].busy, sample_rows[r].typed,
                  sample_rows[r].res);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      rnd = {$urandom, $urandom};
      case (ph)
        0: win = 40'd100000000;
        1: win = '0;
        2: win = '1;
        4: win = WINDOW_RESET;
        6: win = 40'd1;
        default: win = (rnd[WINDOW_W-1:0] < 40'd100000000) ?
                       rnd[WINDOW_W-1:0] + 40'd100000000 : rnd[WINDOW_W-1:0];
      endcase
      write_window(win);
      cur_wall = (ph == 4) ? 64'hFFFF_FFFF_FFFF_FFFF - 64'(win) * 64'd3 : {$urandom, $urandom};
      cur_busy = {$urandom, $urandom};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) idle_on = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
        if (ph == 3 && n == 100) hold_req = 1'b1;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
          wall = {$urandom, $urandom};
          busy = {$urandom, $urandom};
        end else begin
          if (sel < 12) begin
            cur_wall = cur_wall - 64'($urandom_range(1, 1 << 20));
            cur_busy = cur_busy - 64'($urandom_range(0, 1 << 20));
          end else if (sel < 16) begin
            cur_busy = cur_busy + 64'($urandom_range(0, 100));
          end else begin
            dw = (64'(window_reg) >> $urandom_range(0, 8)) + 64'($urandom_range(1, 5000));
            cur_wall = cur_wall + dw;
            cur_busy = cur_busy + ((dw * 64'($urandom_range(0, 300))) >> 8);
          end
          wall = cur_wall;
          busy = cur_busy;
        end
        send_sample(wall, busy, 1'b0, none);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_ratios.size() != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    if (mismatches == 0 && pending_ratios.size() == 0)
      $display("windowed_busy_ratio_monitor_top test passed");
    else
      $display("windowed_busy_ratio_monitor_top test failed");
    $finish;
  end

endmodule
